// ----- hw/rtl/srwm_pkg.sv -----
// Package for the sorted run window merge: shared constants and job/result types.
package srwm_pkg;

	// rows looked at by one merged row: itself and up to two later rows
	localparam int WIN_DEPTH   = 3;
	// sources that can report presence
	localparam int SRC_COUNT   = 3;
	// entries in the queue between front and back
	localparam int QUEUE_DEPTH = 2;

	localparam int SRC_W    = 2;
	localparam int SECTOR_W = 16;
	localparam int PERIOD_W = 32;

	// classified job handed from front to back (payloads travel beside it)
	typedef struct packed {
		logic                                 canon;
		logic                                 real_row;
		logic                                 last;
		logic [PERIOD_W-1:0]                  period;
		logic [WIN_DEPTH-1:0]                 match;
		logic [WIN_DEPTH-1:0][SRC_W-1:0]      src;
		logic [WIN_DEPTH-1:0][SECTOR_W-1:0]   sector;
	} job_ctl_t;

	// result flags, is_canonical in bit 0
	typedef struct packed {
		logic                 sector_mismatch;
		logic [SRC_COUNT-1:0] has_source;
		logic                 is_live;
		logic                 is_canonical;
	} res_flags_t;

endpackage

// ----- hw/rtl/sorted_run_window_merge_top.sv -----
// Top level of the sorted run window merge: stream ports, front, job queue and back.
//
//  channel | dir | handshake          | contents
//  s_*     | in  | s_tvalid/s_tready  | one sorted row, s_tlast marks the bin's last row
//  m_*     | out | m_tvalid/m_tready  | one merged row, m_tlast marks the bin's final result
//
// One row is taken per cycle in steady state; a result leaves two rows later, or at a flush.
// A flush with two rows buffered holds s_tready low while the front drains its
// three-slot window, one job per cycle into the two-entry queue while it has room.
// Reset (arst_n low) empties window and queue and arms the bin start; no clearing pass.
// Output stalls back up through the result register and queue to s_tready.
module sorted_run_window_merge_top #(
	parameter int KEY_WIDTH     = 64,
	parameter int PAYLOAD_WIDTH = 64
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// row_key, row_sector, row_period, row_payload, zero pad
	input  logic [((KEY_WIDTH+48+PAYLOAD_WIDTH+7)/8)*8-1:0] s_tdata,
	// row_source[1:0], row_real[2]
	input  logic [2:0]                            s_tuser,
	input  logic                                  s_tlast,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// payload_source0, payload_source1, payload_source2, lead_sector, merged_period, zero pad
	output logic [((3*PAYLOAD_WIDTH+48+7)/8)*8-1:0] m_tdata,
	// is_canonical, is_live, has_source0, has_source1, has_source2, sector_mismatch
	output logic [5:0]                            m_tuser,
	output logic                                  m_tlast
);

	localparam int SW       = srwm_pkg::SECTOR_W;
	localparam int PW_      = srwm_pkg::PERIOD_W;
	localparam int SEC_LO   = KEY_WIDTH;
	localparam int PER_LO   = SEC_LO + SW;
	localparam int PAY_LO   = PER_LO + PW_;
	localparam int OUT_BITS = 3*PAYLOAD_WIDTH + SW + PW_;
	localparam int OUT_TW   = ((OUT_BITS + 7) / 8) * 8;
	localparam int JOB_W    = $bits(srwm_pkg::job_ctl_t) + srwm_pkg::WIN_DEPTH*PAYLOAD_WIDTH;
	localparam int JP_W     = srwm_pkg::WIN_DEPTH*PAYLOAD_WIDTH;

	logic                 f_push;
	srwm_pkg::job_ctl_t   f_ctl;
	logic [JP_W-1:0]      f_payload;
	logic                 q_ready;
	logic                 q_valid;
	logic                 q_pop;
	logic [JOB_W-1:0]     q_data;
	srwm_pkg::job_ctl_t   b_ctl;
	logic [JP_W-1:0]      b_payload;

	logic [PAYLOAD_WIDTH-1:0] pay0;
	logic [PAYLOAD_WIDTH-1:0] pay1;
	logic [PAYLOAD_WIDTH-1:0] pay2;
	logic [SW-1:0]            sector;
	logic [PW_-1:0]           period;
	srwm_pkg::res_flags_t     flags;

	srwm_front #(
		.KEY_WIDTH     (KEY_WIDTH),
		.PAYLOAD_WIDTH (PAYLOAD_WIDTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.row_key     (s_tdata[SEC_LO-1:0]),
		.row_source  (s_tuser[1:0]),
		.row_real    (s_tuser[2]),
		.row_sector  (s_tdata[PER_LO-1:SEC_LO]),
		.row_period  (s_tdata[PAY_LO-1:PER_LO]),
		.row_payload (s_tdata[PAY_LO+PAYLOAD_WIDTH-1:PAY_LO]),
		.end_of_bin  (s_tlast),
		.q_ready     (q_ready),
		.q_push      (f_push),
		.q_ctl       (f_ctl),
		.q_payload   (f_payload)
	);

	srwm_queue #(
		.WIDTH (JOB_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (f_push),
		.push_data ({f_ctl, f_payload}),
		.ready     (q_ready),
		.pop       (q_pop),
		.pop_data  (q_data),
		.valid     (q_valid)
	);

	assign b_ctl     = q_data[JOB_W-1:JP_W];
	assign b_payload = q_data[JP_W-1:0];

	srwm_back #(
		.PAYLOAD_WIDTH (PAYLOAD_WIDTH)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_valid         (q_valid),
		.q_pop           (q_pop),
		.q_ctl           (b_ctl),
		.q_payload       (b_payload),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.payload_source0 (pay0),
		.payload_source1 (pay1),
		.payload_source2 (pay2),
		.lead_sector     (sector),
		.merged_period   (period),
		.flags           (flags),
		.last_of_bin     (m_tlast)
	);

	// pack result fields, lowest field first
	assign m_tdata = OUT_TW'({period, sector, pay2, pay1, pay0});
	assign m_tuser = flags;

endmodule

// ----- hw/rtl/srwm_front.sv -----
// Front part: accepts rows, holds the lookahead window and classifies each emitted row.
module srwm_front #(
	parameter int KEY_WIDTH     = 64,
	parameter int PAYLOAD_WIDTH = 64
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	// input rows
	input  logic                                     s_tvalid,
	output logic                                     s_tready,
	input  logic [KEY_WIDTH-1:0]                     row_key,
	input  logic [srwm_pkg::SRC_W-1:0]               row_source,
	input  logic                                     row_real,
	input  logic [srwm_pkg::SECTOR_W-1:0]            row_sector,
	input  logic [srwm_pkg::PERIOD_W-1:0]            row_period,
	input  logic [PAYLOAD_WIDTH-1:0]                 row_payload,
	input  logic                                     end_of_bin,
	// job queue
	input  logic                                     q_ready,
	output logic                                     q_push,
	output srwm_pkg::job_ctl_t                       q_ctl,
	output logic [srwm_pkg::WIN_DEPTH*PAYLOAD_WIDTH-1:0] q_payload
);

	localparam int WD = srwm_pkg::WIN_DEPTH;

	// window slots, slot 0 is the oldest row
	logic [KEY_WIDTH-1:0]              key_q     [WD];
	logic [srwm_pkg::SRC_W-1:0]        src_q     [WD];
	logic                              real_q    [WD];
	logic [srwm_pkg::SECTOR_W-1:0]     sector_q  [WD];
	logic [srwm_pkg::PERIOD_W-1:0]     period_q  [WD];
	logic [PAYLOAD_WIDTH-1:0]          payload_q [WD];

	logic [1:0]           fill_q;
	logic                 drain_q;
	logic                 bin_start_q;
	logic [KEY_WIDTH-1:0] prev_key_q;
	logic                 prev_real_q;

	logic       push;
	logic       accept;
	logic       last_job;
	logic [1:0] fill_sh;
	logic       canon;

	// emit the oldest row when the window is full or a flush is running
	assign push     = (drain_q || (fill_q == 2'd3)) && q_ready;
	assign last_job = drain_q && (fill_q == 2'd1);
	assign s_tready = !drain_q && ((fill_q != 2'd3) || q_ready);
	assign accept   = s_tvalid && s_tready;
	assign fill_sh  = fill_q - {1'b0, push};
	assign q_push   = push;

	assign canon = bin_start_q || !prev_real_q || (prev_key_q != key_q[0]) || !real_q[0];

	// classify the head row against the rows in the window
	always_comb begin
		q_ctl          = '0;
		q_ctl.canon    = canon;
		q_ctl.real_row = real_q[0];
		q_ctl.last     = last_job;
		q_ctl.period   = period_q[0];
		for (int j = 0; j < WD; j++) begin
			q_ctl.match[j]  = real_q[0] && real_q[j] && (fill_q > 2'(j))
				&& (key_q[j] == key_q[0]);
			q_ctl.src[j]    = src_q[j];
			q_ctl.sector[j] = sector_q[j];
			q_payload[j*PAYLOAD_WIDTH +: PAYLOAD_WIDTH] = payload_q[j];
		end
	end

	// window control and run tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			drain_q     <= 1'b0;
			bin_start_q <= 1'b1;
			prev_key_q  <= '0;
			prev_real_q <= 1'b0;
		end else begin
			fill_q <= fill_sh + {1'b0, accept};
			if (accept && end_of_bin) begin
				drain_q <= 1'b1;
			end else if (push && last_job) begin
				drain_q <= 1'b0;
			end
			if (push) begin
				bin_start_q <= last_job;
				prev_key_q  <= key_q[0];
				prev_real_q <= real_q[0];
			end
		end
	end

	// window slots: shift on emit, new row lands behind the remaining ones
	always_ff @(posedge clk) begin
		for (int k = 0; k < WD - 1; k++) begin
			if (accept && (fill_sh == 2'(k))) begin
				key_q[k]     <= row_key;
				src_q[k]     <= row_source;
				real_q[k]    <= row_real;
				sector_q[k]  <= row_sector;
				period_q[k]  <= row_period;
				payload_q[k] <= row_payload;
			end else if (push) begin
				key_q[k]     <= key_q[k+1];
				src_q[k]     <= src_q[k+1];
				real_q[k]    <= real_q[k+1];
				sector_q[k]  <= sector_q[k+1];
				period_q[k]  <= period_q[k+1];
				payload_q[k] <= payload_q[k+1];
			end
		end
		if (accept && (fill_sh == 2'(WD - 1))) begin
			key_q[WD-1]     <= row_key;
			src_q[WD-1]     <= row_source;
			real_q[WD-1]    <= row_real;
			sector_q[WD-1]  <= row_sector;
			period_q[WD-1]  <= row_period;
			payload_q[WD-1] <= row_payload;
		end
	end

`ifndef SYNTHESIS
	// no row enters while a flush is running
	a_drain_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		drain_q |-> !s_tready)
		else $error("row accepted during flush");

	// the last row of a flush ends the drain and re-arms bin start
	a_flush_end: assert property (@(posedge clk) disable iff (!arst_n)
		(push && last_job) |=> (bin_start_q && !drain_q && (fill_q == 2'd0)))
		else $error("flush did not end cleanly");
`endif

endmodule

// ----- hw/rtl/srwm_queue.sv -----
// Short job queue between the front and back parts.
module srwm_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             ready,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             valid
);

	localparam int DEPTH = srwm_pkg::QUEUE_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign ready    = (count_q != CNT_W'(DEPTH));
	assign valid    = (count_q != '0);
	assign pop_data = entry_q[rd_ptr_q];

	// pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q != CNT_W'(DEPTH)))
		else $error("job queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != '0))
		else $error("job queue underflow");
`endif

endmodule

// ----- hw/rtl/srwm_back.sv -----
// Back part: merges the window matches of one job and drives the result register.
module srwm_back #(
	parameter int PAYLOAD_WIDTH = 64
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	// job queue
	input  logic                                         q_valid,
	output logic                                         q_pop,
	input  srwm_pkg::job_ctl_t                           q_ctl,
	input  logic [srwm_pkg::WIN_DEPTH*PAYLOAD_WIDTH-1:0] q_payload,
	// merged results
	output logic                                         m_tvalid,
	input  logic                                         m_tready,
	output logic [PAYLOAD_WIDTH-1:0]                     payload_source0,
	output logic [PAYLOAD_WIDTH-1:0]                     payload_source1,
	output logic [PAYLOAD_WIDTH-1:0]                     payload_source2,
	output logic [srwm_pkg::SECTOR_W-1:0]                lead_sector,
	output logic [srwm_pkg::PERIOD_W-1:0]                merged_period,
	output srwm_pkg::res_flags_t                         flags,
	output logic                                         last_of_bin
);

	localparam int WD = srwm_pkg::WIN_DEPTH;
	localparam int NS = srwm_pkg::SRC_COUNT;

	logic [NS-1:0]                 has;
	logic [PAYLOAD_WIDTH-1:0]      pay [NS];
	logic                          seen;
	logic [srwm_pkg::SECTOR_W-1:0] chosen;
	logic [WD-1:0]                 counted;
	logic                          mismatch;
	logic                          hit;

	logic                          tvalid_q;
	logic [PAYLOAD_WIDTH-1:0]      pay_q [NS];
	logic [srwm_pkg::SECTOR_W-1:0] sector_q;
	logic [srwm_pkg::PERIOD_W-1:0] period_q;
	srwm_pkg::res_flags_t          flags_q;
	logic                          last_q;

	assign q_pop = q_valid && (!tvalid_q || m_tready);

	// per source: first match gives presence and payload; source order sets sector
	always_comb begin
		has      = '0;
		seen     = 1'b0;
		chosen   = '0;
		counted  = '0;
		mismatch = 1'b0;
		hit      = 1'b0;
		for (int s = 0; s < NS; s++) begin
			pay[s] = '0;
		end
		for (int s = 0; s < NS; s++) begin
			for (int j = 0; j < WD; j++) begin
				hit = q_ctl.match[j] && (q_ctl.src[j] == srwm_pkg::SRC_W'(s));
				if (hit && !has[s]) begin
					has[s] = 1'b1;
					pay[s] = q_payload[j*PAYLOAD_WIDTH +: PAYLOAD_WIDTH];
				end
				if (hit && !seen) begin
					seen   = 1'b1;
					chosen = q_ctl.sector[j];
				end
				if (hit) begin
					counted[j] = 1'b1;
				end
			end
		end
		// any counted row on a different sector flags a conflict
		for (int j = 0; j < WD; j++) begin
			if (counted[j] && (q_ctl.sector[j] != chosen)) begin
				mismatch = 1'b1;
			end
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tvalid_q <= 1'b0;
		end else if (!tvalid_q || m_tready) begin
			tvalid_q <= q_valid;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (q_pop) begin
			for (int s = 0; s < NS; s++) begin
				pay_q[s] <= pay[s];
			end
			sector_q                <= chosen;
			period_q                <= q_ctl.real_row ? q_ctl.period : '0;
			flags_q.is_canonical    <= q_ctl.canon;
			flags_q.is_live         <= q_ctl.canon && (has != '0);
			flags_q.has_source      <= has;
			flags_q.sector_mismatch <= mismatch;
			last_q                  <= q_ctl.last;
		end
	end

	assign m_tvalid        = tvalid_q;
	assign payload_source0 = pay_q[0];
	assign payload_source1 = pay_q[1];
	assign payload_source2 = pay_q[2];
	assign lead_sector     = sector_q;
	assign merged_period   = period_q;
	assign flags           = flags_q;
	assign last_of_bin     = last_q;

`ifndef SYNTHESIS
	a_mismatch_needs_match: assert property (@(posedge clk) disable iff (!arst_n)
		(tvalid_q && flags_q.sector_mismatch) |-> (flags_q.has_source != '0))
		else $error("sector conflict without any source match");

	a_live_is_canonical: assert property (@(posedge clk) disable iff (!arst_n)
		(tvalid_q && flags_q.is_live) |-> flags_q.is_canonical)
		else $error("live row that is not canonical");
`endif

endmodule

// ----- dv/tb_top.sv -----
// Testbench for sorted_run_window_merge_top: bin stimulus, merge predictor and result checker.
`timescale 1ns / 100ps

module tb_top;

	localparam int KW = 64;
	localparam int PW = 64;
	localparam int S_DW = ((KW + 48 + PW + 7) / 8) * 8;
	localparam int M_DW = ((3 * PW + 48 + 7) / 8) * 8;

	// one sorted row; drain_first holds it back until all merged rows are out
	typedef struct {
		logic [63:0] key;
		logic [1:0]  src;
		logic        is_real;
		logic [15:0] sector;
		logic [31:0] period;
		logic [63:0] payload;
		logic        eob;
		logic        drain_first;
	} row_t;

	// one merged result row
	typedef struct {
		logic        canonical;
		logic        live;
		logic [2:0]  has_src;
		logic [63:0] pay [3];
		logic [15:0] sector;
		logic        mismatch;
		logic [31:0] period;
		logic        last;
	} merged_t;

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            s_tvalid = 1'b0;
	logic            s_tready;
	logic [S_DW-1:0] s_tdata = '0;
	logic [2:0]      s_tuser = '0;
	logic            s_tlast = 1'b0;
	logic            m_tvalid;
	logic            m_tready = 1'b0;
	logic [M_DW-1:0] m_tdata;
	logic [5:0]      m_tuser;
	logic            m_tlast;

	// row stream and expected merges
	row_t    row_queue [$];
	merged_t expected_merges [$];
	row_t    cur_row;
	int      gap_left = 0;
	int      burst_left = 1;
	int      rows_accepted = 0;
	int      mismatches = 0;

	// predictor state: lookahead window and run tracking
	row_t        win [3];
	int          win_fill = 0;
	logic [63:0] prev_key = '0;
	logic        prev_real = 1'b0;
	logic        bin_start = 1'b1;

	// receiver stall state
	int   rx_cycle = 0;
	int   hold_left = 0;
	logic long_hold_done = 1'b0;

	sorted_run_window_merge_top #(
		.KEY_WIDTH(KW),
		.PAYLOAD_WIDTH(PW)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	always #10 clk = ~clk;

	// merged row for rows[i], looking at rows[i] and up to two later rows
	task automatic merge_one(input row_t rows [3], input int n, input int i, input logic last);
		merged_t     m;
		int          lim;
		logic        seen;
		logic [15:0] first_sec;
		lim = (i + 3 < n) ? i + 3 : n;
		m.canonical = bin_start || !prev_real || prev_key != rows[i].key || !rows[i].is_real;
		m.has_src = '0;
		m.pay = '{default: '0};
		m.sector = '0;
		m.mismatch = 1'b0;
		seen = 1'b0;
		first_sec = '0;
		prev_key = rows[i].key;
		prev_real = rows[i].is_real;
		bin_start = 1'b0;
		if (rows[i].is_real) begin
			for (int s = 0; s < 3; s++) begin
				for (int j = i; j < lim; j++) begin
					if (rows[j].src == s && rows[j].is_real && rows[j].key == rows[i].key) begin
						if (!m.has_src[s]) begin
							m.has_src[s] = 1'b1;
							m.pay[s] = rows[j].payload;
						end
						if (!seen) begin
							seen = 1'b1;
							first_sec = rows[j].sector;
							m.sector = rows[j].sector;
						end else if (rows[j].sector != first_sec) begin
							m.mismatch = 1'b1;
						end
					end
				end
			end
		end
		m.live = m.canonical && (|m.has_src);
		m.period = rows[i].is_real ? rows[i].period : '0;
		m.last = last;
		expected_merges.insert(expected_merges.size(), m);
	endtask

	// advance the window by one accepted row, flushing at the bin's end
	task automatic merge_row(input row_t r);
		row_t rows [3];
		int   n;
		n = win_fill;
		for (int i = 0; i < n; i++) rows[i] = win[i];
		rows[n] = r;
		n++;
		if (r.eob) begin
			for (int i = 0; i < n; i++) merge_one(rows, n, i, i == n - 1);
			win_fill = 0;
			bin_start = 1'b1;
		end else begin
			if (n == 3) begin
				merge_one(rows, 3, 0, 1'b0);
				rows[0] = rows[1];
				rows[1] = rows[2];
				n = 2;
			end
			for (int i = 0; i < n; i++) win[i] = rows[i];
			win_fill = n;
		end
	endtask

	task automatic add_row(input logic [63:0] key, input logic [1:0] src, input logic is_real,
			input logic [15:0] sector, input logic [31:0] period, input logic [63:0] payload,
			input logic eob, input logic drain_first);
		row_t r;
		r.key = key;
		r.src = src;
		r.is_real = is_real;
		r.sector = sector;
		r.period = period;
		r.payload = payload;
		r.eob = eob;
		r.drain_first = drain_first;
		row_queue.insert(row_queue.size(), r);
	endtask

	task automatic check_field(input string name, input logic [63:0] exp_v, input logic [63:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %h, got %h", name, exp_v, act_v);
			mismatches++;
		end
	endtask

	// row driver: bursts with random gaps, optional drain before a marked row
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
			s_tlast <= 1'b0;
			gap_left = 0;
			burst_left = 1;
		end else if (!s_tvalid || s_tready) begin
			if (s_tvalid) begin
				merge_row(cur_row);
				rows_accepted <= rows_accepted + 1;
			end
			if (gap_left > 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (row_queue.size() > 0 &&
					!(row_queue[0].drain_first && expected_merges.size() > 0)) begin
				cur_row = row_queue.pop_front();
				s_tdata <= {cur_row.payload, cur_row.period, cur_row.sector, cur_row.key};
				s_tuser <= {cur_row.is_real, cur_row.src};
				s_tlast <= cur_row.eob;
				s_tvalid <= 1'b1;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 12);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver: free-running stretches, random stalls, one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_cycle <= 0;
			hold_left <= 0;
			long_hold_done <= 1'b0;
		end else begin
			rx_cycle <= rx_cycle + 1;
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				m_tready <= 1'b0;
			end else if (!long_hold_done && rows_accepted >= 40) begin
				hold_left <= 80;
				long_hold_done <= 1'b1;
				m_tready <= 1'b0;
			end else if (rx_cycle[6:5] == 2'd0) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= ($urandom_range(0, 3) != 0);
			end
		end
	end

	// result monitor: compare each transaction with the oldest expected merge
	always @(posedge clk) begin
		merged_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_merges.size() == 0) begin
				$error("merged row with none expected: tuser %h tdata %h", m_tuser, m_tdata);
				mismatches++;
			end else begin
				e = expected_merges.pop_front();
				check_field("is_canonical", e.canonical, m_tuser[0]);
				check_field("is_live", e.live, m_tuser[1]);
				check_field("has_source0", e.has_src[0], m_tuser[2]);
				check_field("has_source1", e.has_src[1], m_tuser[3]);
				check_field("has_source2", e.has_src[2], m_tuser[4]);
				check_field("sector_mismatch", e.mismatch, m_tuser[5]);
				check_field("payload_source0", e.pay[0], m_tdata[63:0]);
				check_field("payload_source1", e.pay[1], m_tdata[127:64]);
				check_field("payload_source2", e.pay[2], m_tdata[191:128]);
				check_field("lead_sector", e.sector, m_tdata[207:192]);
				check_field("merged_period", e.period, m_tdata[239:208]);
				check_field("last_of_bin", e.last, m_tlast);
			end
		end
	end

	// stimulus, reset and end of run
	initial begin
		logic [63:0] key;
		logic [1:0]  src;
		int          n;
		int          total;
		logic        first_bin;
		// lone dummy row with key, source, sector, period and payload at their top values
		add_row('1, 2'd3, 1'b0, '1, '1, '1, 1'b1, 1'b0);
		// one key from all three sources, sectors disagree; flush with two buffered
		add_row(64'h10, 2'd0, 1'b1, 16'h0001, 32'h1, '1, 1'b0, 1'b1);
		add_row(64'h10, 2'd1, 1'b1, 16'h0002, 32'h2, 64'h8000_0000_0000_0001, 1'b0, 1'b0);
		add_row(64'h10, 2'd2, 1'b1, 16'h0001, 32'h3, 64'h1, 1'b1, 1'b0);
		// duplicate source, source three, dummy inside a run, full window
		add_row(64'h0, 2'd0, 1'b1, 16'h0007, 32'h10, 64'h1, 1'b0, 1'b0);
		add_row(64'h0, 2'd0, 1'b1, 16'h0007, 32'h11, 64'h2, 1'b0, 1'b0);
		add_row(64'h0, 2'd1, 1'b1, 16'h0007, 32'h12, 64'h3, 1'b0, 1'b0);
		add_row(64'h0, 2'd3, 1'b1, 16'h0009, 32'h13, 64'h4, 1'b0, 1'b0);
		add_row(64'h5, 2'd2, 1'b1, 16'h0003, 32'h14, 64'h5, 1'b0, 1'b0);
		add_row(64'h5, 2'd0, 1'b0, 16'h0003, 32'h15, 64'h6, 1'b0, 1'b0);
		add_row(64'h5, 2'd1, 1'b1, 16'h0004, 32'h16, 64'h7, 1'b0, 1'b0);
		add_row(64'h6, 2'd0, 1'b1, 16'h0005, 32'h17, 64'h8, 1'b1, 1'b0);
		// top key, source three at the bin's end; flush with one buffered
		add_row('1, 2'd2, 1'b1, '1, '1, '1, 1'b0, 1'b0);
		add_row('1, 2'd3, 1'b1, 16'h0, 32'h0, 64'h0, 1'b1, 1'b0);
		// same key across a bin boundary still starts a run
		add_row(64'h1, 2'd1, 1'b1, 16'h00A5, 32'h20, 64'h9, 1'b1, 1'b0);
		add_row(64'h1, 2'd1, 1'b1, 16'h00A5, 32'h21, 64'hA, 1'b1, 1'b0);
		// dummy then real row with all-zero fields
		add_row(64'h0, 2'd0, 1'b0, 16'h0, 32'h0, 64'h0, 1'b0, 1'b0);
		add_row(64'h0, 2'd0, 1'b1, 16'h0, 32'h0, 64'h0, 1'b1, 1'b0);

		// random bins: mostly sorted runs, some noise rows
		total = 0;
		first_bin = 1'b1;
		while (total < 82) begin
			n = $urandom_range(1, 8);
			key = {$urandom, $urandom};
			src = 2'($urandom_range(0, 2));
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(0, 9) == 0) begin
					add_row({$urandom, $urandom}, 2'($urandom_range(0, 3)),
						1'($urandom_range(0, 1)),
						16'($urandom), $urandom, {$urandom, $urandom}, i == n - 1,
						i == 0 && (first_bin || $urandom_range(0, 4) == 0));
				end else begin
					if (i > 0) begin
						if ($urandom_range(0, 2) != 0 && src < 2) begin
							src++;
						end else begin
							key += $urandom_range(1, 3);
							src = 2'($urandom_range(0, 2));
						end
					end
					add_row(key, ($urandom_range(0, 19) == 0) ? 2'd3 : src,
						$urandom_range(0, 7) != 0,
						($urandom_range(0, 1) == 0) ? 16'h00A5 : 16'($urandom),
						$urandom, {$urandom, $urandom}, i == n - 1,
						i == 0 && (first_bin || $urandom_range(0, 4) == 0));
				end
			end
			first_bin = 1'b0;
			total += n;
		end

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (row_queue.size() > 0 || s_tvalid || expected_merges.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// run limit
	initial begin
		#2_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
